// File: hdl/texunp_pkg.sv
// ----------------------------------------------------------------------------
// texunp_pkg
// Types, codes and the channel widening function shared by the texel unpacker.
// ----------------------------------------------------------------------------
package texunp_pkg;

  typedef enum logic [1:0] {
    FMT_PALETTE8 = 2'd0,
    FMT_PACKED16 = 2'd1,
    FMT_RGB24    = 2'd2,
    FMT_GBXR32   = 2'd3
  } pixel_format_t;

  typedef enum logic [1:0] {
    LAYOUT_565    = 2'd0,
    LAYOUT_5551   = 2'd1,
    LAYOUT_4444   = 2'd2,
    LAYOUT_332_A8 = 2'd3
  } alpha_layout_t;

  typedef enum logic {
    OP_TEXEL_BYTE  = 1'b0,
    OP_PALETTE_WR  = 1'b1
  } opcode_t;

  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] REG_ALPHA_LAYOUT = 3'd4;

  typedef struct packed {
    pixel_format_t fmt;
    alpha_layout_t layout;
    logic          pal_in_range;
    logic [7:0]    b0;
    logic [7:0]    b1;
    logic [7:0]    last;
  } pix_job_t;

  // Exact floor(255*v/(2^n-1)). The fraction v/(2^n-1) is the n-bit pattern
  // repeated forever; 24 bits of it, rounded up by one, times 255 lands in
  // the right integer because the true fraction is a multiple of 1/(2^n-1).
  function automatic logic [7:0] widen(input logic [7:0] v, input int n);
    logic [47:0] acc;
    logic [24:0] a1;
    logic [32:0] p;
    acc = '0;
    for (int i = 0; i < 24; i++) begin
      if (n * (i + 1) <= 48) begin
        acc = acc | ({40'd0, v} << (48 - n * (i + 1)));
      end
    end
    a1 = {1'b0, acc[47:24]} + 25'd1;
    p  = {a1, 8'd0} - {8'd0, a1};
    return p[31:24];
  endfunction

endpackage

// File: hdl/texunp_ram.sv
// ----------------------------------------------------------------------------
// texunp_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module texunp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/texel_unpack_to_rgba8.sv
// ----------------------------------------------------------------------------
// texel_unpack_to_rgba8
// Converts decompressed texture bytes into RGBA8 pixels, with a palette RAM.
// ----------------------------------------------------------------------------
// A pixel's last byte is registered in the first stage, then in the output
// register that drives tvalid. Throughput: one input transfer per cycle
// unless the output stalls; the palette RAM read is registered alongside
// the first stage. Reset clears the byte phase, the partial bytes and both
// valid flags, not the stage data. The palette RAM is not cleared and is undefined until written.
module texel_unpack_to_rgba8
  import texunp_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // data_byte, frame_start, palette_index, palette_rgb, zero fill
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // red, green, blue, alpha
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  pixel_format_t pixel_format;
  alpha_layout_t alpha_layout;
  logic [1:0]    byte_phase;
  logic [23:0]   partial_bytes;
  logic          s1_valid;
  pix_job_t      s1_job;
  logic [23:0]   pal_rdata;

  logic [7:0]    in_byte;
  logic          in_fstart;
  logic [7:0]    in_pidx;
  logic [23:0]   in_prgb;
  logic          accept;
  logic          out_free;
  logic          is_byte;
  logic [1:0]    phase_eff;
  logic          complete;
  logic          pal_wr;
  logic          pal_rd;
  logic          byte_in_range;
  logic [7:0]    r_c, g_c, b_c, a_c;
  logic [15:0]   word16;

  assign in_byte   = s_tdata[7:0];
  assign in_fstart = s_tdata[8];
  assign in_pidx   = s_tdata[16:9];
  assign in_prgb   = s_tdata[40:17];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || out_free;
  assign accept    = s_tvalid && s_tready;
  assign is_byte   = (opcode_t'(s_tuser) == OP_TEXEL_BYTE);
  assign phase_eff = in_fstart ? 2'd0 : byte_phase;
  assign complete  = (phase_eff >= 2'(pixel_format));

  assign byte_in_range = ({1'b0, in_byte} < PAL_LIMIT);
  assign pal_wr = accept && !is_byte && ({1'b0, in_pidx} < PAL_LIMIT);
  assign pal_rd = accept && is_byte && complete && (pixel_format == FMT_PALETTE8)
                  && byte_in_range;

  texunp_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (pal_wr),
    .waddr(in_pidx[AW-1:0]),
    .wdata(in_prgb),
    .re   (pal_rd),
    .raddr(in_byte[AW-1:0]),
    .rdata(pal_rdata)
  );

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_PALETTE8;
      alpha_layout <= LAYOUT_565;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ALPHA_LAYOUT[2]) begin
        alpha_layout <= alpha_layout_t'(pwdata[1:0]);
      end else begin
        pixel_format <= pixel_format_t'(pwdata[1:0]);
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ALPHA_LAYOUT[2]) begin
      prdata = {30'd0, alpha_layout};
    end else begin
      prdata = {30'd0, pixel_format};
    end
  end

  // Byte assembly and the first pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 2'd0;
      partial_bytes <= 24'd0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept && is_byte && complete) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (accept && is_byte) begin
        if (complete) begin
          byte_phase <= 2'd0;
        end else begin
          byte_phase <= phase_eff + 2'd1;
          unique case (phase_eff)
            2'd0:    partial_bytes[7:0]   <= in_byte;
            2'd1:    partial_bytes[15:8]  <= in_byte;
            2'd2:    partial_bytes[23:16] <= in_byte;
            default: partial_bytes        <= partial_bytes;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte && complete) begin
      s1_job.fmt          <= pixel_format;
      s1_job.layout       <= alpha_layout;
      s1_job.pal_in_range <= byte_in_range;
      s1_job.b0           <= partial_bytes[7:0];
      s1_job.b1           <= partial_bytes[15:8];
      s1_job.last         <= in_byte;
    end
  end

  // Channel conversion.
  assign word16 = {s1_job.last, s1_job.b0};

  always_comb begin
    r_c = 8'd0;
    g_c = 8'd0;
    b_c = 8'd0;
    a_c = 8'hff;
    unique case (s1_job.fmt)
      FMT_PALETTE8: begin
        if (s1_job.pal_in_range) begin
          r_c = pal_rdata[23:16];
          g_c = pal_rdata[15:8];
          b_c = pal_rdata[7:0];
        end
      end
      FMT_PACKED16: begin
        unique case (s1_job.layout)
          LAYOUT_565: begin
            r_c = widen({3'd0, word16[15:11]}, 5);
            g_c = widen({2'd0, word16[10:5]}, 6);
            b_c = widen({3'd0, word16[4:0]}, 5);
          end
          LAYOUT_5551: begin
            r_c = widen({3'd0, word16[15:11]}, 5);
            g_c = widen({3'd0, word16[10:6]}, 5);
            b_c = widen({3'd0, word16[5:1]}, 5);
            a_c = word16[0] ? 8'hff : 8'h00;
          end
          LAYOUT_4444: begin
            r_c = widen({4'd0, word16[15:12]}, 4);
            g_c = widen({4'd0, word16[11:8]}, 4);
            b_c = widen({4'd0, word16[7:4]}, 4);
            a_c = widen({4'd0, word16[3:0]}, 4);
          end
          LAYOUT_332_A8: begin
            r_c = widen({5'd0, word16[15:13]}, 3);
            g_c = widen({5'd0, word16[12:10]}, 3);
            b_c = widen({6'd0, word16[9:8]}, 2);
            a_c = word16[7:0];
          end
          default: begin
            a_c = 8'hff;
          end
        endcase
      end
      FMT_RGB24: begin
        r_c = s1_job.b0;
        g_c = s1_job.b1;
        b_c = s1_job.last;
      end
      FMT_GBXR32: begin
        r_c = s1_job.last;
        g_c = s1_job.b0;
        b_c = s1_job.b1;
      end
      default: begin
        a_c = 8'hff;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {a_c, b_c, g_c, r_c};
    end
  end

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_job))
    else $error("stage one changed while the output was stalled");

  a_rd_only_palette: assert property (@(posedge clk) disable iff (rst)
    pal_rd |-> accept && is_byte && pixel_format == FMT_PALETTE8 && !pal_wr)
    else $error("palette read without an accepted palette pixel");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s1_valid && byte_phase == 2'd0)
    else $error("pipeline not empty after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled with an empty first stage");

endmodule
